@@ hw/rtl/sskpl_pkg.sv @@
package sskpl_pkg;

    // Q0.24 fraction bits and the serial multiplier's second operand width
    localparam int FRAC_BITS = 24;
    localparam int MB = 25;
    localparam int CFG_IW = 3;
    localparam int CFG_DW = 24;

    localparam logic [24:0] ONE_Q24    = 25'd16777216;
    localparam logic [23:0] ATTACK_Q24 = 24'd13086228;

    // register indexes
    localparam logic [CFG_IW-1:0] REG_ENABLE    = 3'd0;
    localparam logic [CFG_IW-1:0] REG_THRESHOLD = 3'd1;
    localparam logic [CFG_IW-1:0] REG_RELEASE   = 3'd2;
    localparam logic [CFG_IW-1:0] REG_KNEE      = 3'd3;
    localparam logic [CFG_IW-1:0] REG_CEILING   = 3'd4;

    localparam logic [22:0] THRESHOLD_RST = 23'd8103826;
    localparam logic [23:0] RELEASE_RST   = 24'd1677722;
    localparam logic [23:0] KNEE_RST      = 24'd1677722;
    localparam logic [22:0] CEILING_RST   = 23'd8103826;

endpackage

@@ hw/rtl/sskpl_mul.sv @@
// Shift-add multiplier, one bit of b per cycle.
module sskpl_mul #(
    parameter int MA = 25
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       start,
    input  logic [MA-1:0]              a,
    input  logic [sskpl_pkg::MB-1:0]   b,
    output logic                       busy,
    output logic [MA+sskpl_pkg::MB-1:0] prod
);
    localparam int PW = MA + sskpl_pkg::MB;

    logic [PW-1:0]            p_reg;
    logic [PW-1:0]            a_reg;
    logic [sskpl_pkg::MB-1:0] b_reg;
    logic [4:0]               cnt_reg;
    logic                     busy_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end else if (start && !busy_reg) begin
            busy_reg <= 1'b1;
            cnt_reg  <= '0;
        end else if (busy_reg) begin
            cnt_reg <= cnt_reg + 5'd1;
            if (cnt_reg == 5'(sskpl_pkg::MB - 1)) begin
                busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start && !busy_reg) begin
            p_reg <= '0;
            a_reg <= PW'(a);
            b_reg <= b;
        end else if (busy_reg) begin
            if (b_reg[0]) begin
                p_reg <= p_reg + a_reg;
            end
            a_reg <= {a_reg[PW-2:0], 1'b0};
            b_reg <= {1'b0, b_reg[sskpl_pkg::MB-1:1]};
        end
    end

    assign busy = busy_reg;
    assign prod = p_reg;
endmodule

@@ hw/rtl/sskpl_div.sv @@
// Restoring divider: floor(num * 2^24 / den) for num < den, one quotient bit per cycle.
module sskpl_div #(
    parameter int DW = 48
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           start,
    input  logic [DW-1:0]                  num,
    input  logic [DW-1:0]                  den,
    output logic                           busy,
    output logic [sskpl_pkg::FRAC_BITS-1:0] quo
);
    logic [DW-1:0]                   rem_reg;
    logic [DW-1:0]                   den_reg;
    logic [sskpl_pkg::FRAC_BITS-1:0] q_reg;
    logic [4:0]                      cnt_reg;
    logic                            busy_reg;
    logic [DW:0]                     trial;

    assign trial = {rem_reg, 1'b0};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end else if (start && !busy_reg) begin
            busy_reg <= 1'b1;
            cnt_reg  <= '0;
        end else if (busy_reg) begin
            cnt_reg <= cnt_reg + 5'd1;
            if (cnt_reg == 5'(sskpl_pkg::FRAC_BITS - 1)) begin
                busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start && !busy_reg) begin
            rem_reg <= num;
            den_reg <= den;
            q_reg   <= '0;
        end else if (busy_reg) begin
            if (trial >= {1'b0, den_reg}) begin
                rem_reg <= DW'(trial - {1'b0, den_reg});
                q_reg   <= {q_reg[sskpl_pkg::FRAC_BITS-2:0], 1'b1};
            end else begin
                rem_reg <= trial[DW-1:0];
                q_reg   <= {q_reg[sskpl_pkg::FRAC_BITS-2:0], 1'b0};
            end
        end
    end

    assign busy = busy_reg;
    assign quo  = q_reg;
endmodule

@@ hw/rtl/sskpl_ring.sv @@
// Look-ahead delay memory, one write and one registered read per cycle.
module sskpl_ring #(
    parameter int DEPTH = 128,
    parameter int AW    = 7,
    parameter int DW    = 48
) (
    input  logic          aclk,
    input  logic          wr_en,
    input  logic [AW-1:0] wr_addr,
    input  logic [DW-1:0] wr_data,
    input  logic          rd_en,
    input  logic [AW-1:0] rd_addr,
    output logic [DW-1:0] rd_data
);
    logic [DW-1:0] mem [DEPTH];
    logic [DW-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;
endmodule

@@ hw/rtl/stereo_soft_knee_peak_limiter_core.sv @@
// Channel   Ports                                          Handshake
// input     s_left_sample s_right_sample s_block_end       s_valid / s_ready
// result    m_left_out m_right_out m_block_end_out         m_valid / m_ready
// config    cfg_index cfg_wdata                            cfg_wr_en, no wait
//
// One frame at a time. In limiting, each product goes through the shared
// bit-serial multiplier (up to six per frame) and each quotient through the
// serial divider (up to two). Disabled frames pass unchanged. Reset and
// enable=0 clear state at once; the delay memory is not swept, a fill count
// makes unwritten entries read zero.
// The next request is taken while a result still waits for m_ready.
module stereo_soft_knee_peak_limiter_core #(
    parameter int DELAY_FRAMES = 72,
    parameter int RING_DEPTH   = 128,
    parameter int SAMPLE_BITS  = 24
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  logic signed [SAMPLE_BITS-1:0]  s_left_sample,
    input  logic signed [SAMPLE_BITS-1:0]  s_right_sample,
    input  logic                           s_block_end,
    output logic                           m_valid,
    input  logic                           m_ready,
    output logic signed [SAMPLE_BITS-1:0]  m_left_out,
    output logic signed [SAMPLE_BITS-1:0]  m_right_out,
    output logic                           m_block_end_out,
    input  logic                           cfg_wr_en,
    input  logic [sskpl_pkg::CFG_IW-1:0]   cfg_index,
    input  logic [sskpl_pkg::CFG_DW-1:0]   cfg_wdata
);
    localparam int W   = SAMPLE_BITS;
    localparam int MA  = (W > 25) ? W : 25;
    localparam int PW  = MA + sskpl_pkg::MB;
    localparam int DW  = (W + 24 > 48) ? W + 24 : 48;
    localparam int CW  = (W > 23) ? W : 23;
    localparam int AW  = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
    localparam int FW  = $clog2(RING_DEPTH + 1);
    localparam int OFF = DELAY_FRAMES % RING_DEPTH;

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_RD   = 4'd1;
    localparam logic [3:0] S_PEAK = 4'd2;
    localparam logic [3:0] S_PKW  = 4'd3;
    localparam logic [3:0] S_THR  = 4'd4;
    localparam logic [3:0] S_RATW = 4'd5;
    localparam logic [3:0] S_KNW  = 4'd6;
    localparam logic [3:0] S_BLW  = 4'd7;
    localparam logic [3:0] S_SMS  = 4'd8;
    localparam logic [3:0] S_SMW  = 4'd9;
    localparam logic [3:0] S_SCL  = 4'd10;
    localparam logic [3:0] S_LW   = 4'd11;
    localparam logic [3:0] S_RW   = 4'd12;
    localparam logic [3:0] S_OUT  = 4'd13;

    logic [3:0]    state_reg;
    logic          enable_reg;
    logic [22:0]   thr_reg;
    logic [23:0]   rc_reg;
    logic [23:0]   kf_reg;
    logic [22:0]   ceil_reg;

    logic [W-1:0]  in_l_reg, in_r_reg;
    logic          in_be_reg;
    logic [W-1:0]  dl_reg, dr_reg;
    logic [W-1:0]  pk_reg;
    logic [W-1:0]  pl_reg;
    logic [24:0]   gain_reg;
    logic [24:0]   target_reg;
    logic [23:0]   ratio_reg;
    logic [23:0]   r_reg;
    logic          down_reg;
    logic          hit_reg, vld_reg;
    logic [AW-1:0] wp_reg;
    logic [FW-1:0] fill_reg;
    logic [W-1:0]  lres_reg, rres_reg;
    logic          m_valid_reg;
    logic [W-1:0]  m_l_reg, m_r_reg;
    logic          m_be_reg;

    logic [AW-1:0]    rd_addr;
    logic [AW-1:0]    wp_next;
    logic [2*W-1:0]   ring_rd;
    logic [W-1:0]     dl_c, dr_c, ml_c, mr_c, peak_c;
    logic [CW-1:0]    pl_x, thr_x, diff_x;
    logic [DW-1:0]    num_c, den_c;
    logic             s_fire;

    logic                            mul_start, mul_busy;
    logic                            div_start, div_busy;
    logic [MA-1:0]                   mul_a;
    logic [sskpl_pkg::MB-1:0]        mul_b;
    logic [PW-1:0]                   prod;
    logic [DW-1:0]                   div_num, div_den;
    logic [sskpl_pkg::FRAC_BITS-1:0] quo;

    function automatic logic [W-1:0] mag(input logic [W-1:0] x);
        return x[W-1] ? W'(-x) : x;
    endfunction

    function automatic logic [W-1:0] clamp(input logic neg, input logic [PW-1:0] p,
                                           input logic [22:0] ceil);
        logic [CW-1:0] m;
        logic [CW-1:0] c;
        logic [CW-1:0] s;
        logic [W-1:0]  v;
        m = CW'(p[W+23:24]);
        c = CW'(ceil);
        s = (m > c) ? c : m;
        v = W'(s);
        return neg ? W'(-v) : v;
    endfunction

    assign s_ready = (state_reg == S_IDLE);
    assign s_fire  = s_valid && s_ready;

    assign rd_addr = (wp_reg >= AW'(OFF)) ? AW'(wp_reg - AW'(OFF))
                                          : AW'(wp_reg + AW'(RING_DEPTH - OFF));
    assign wp_next = (wp_reg == AW'(RING_DEPTH - 1)) ? '0 : AW'(wp_reg + 1'b1);

    sskpl_ring #(.DEPTH(RING_DEPTH), .AW(AW), .DW(2 * W)) u_ring (
        .aclk    (aclk),
        .wr_en   (state_reg == S_RD),
        .wr_addr (wp_reg),
        .wr_data ({in_l_reg, in_r_reg}),
        .rd_en   (state_reg == S_RD),
        .rd_addr (rd_addr),
        .rd_data (ring_rd)
    );

    // delayed frame: same slot as the write takes the fresh input; unwritten slots read zero
    assign dl_c   = hit_reg ? in_l_reg : (vld_reg ? ring_rd[2*W-1:W] : '0);
    assign dr_c   = hit_reg ? in_r_reg : (vld_reg ? ring_rd[W-1:0] : '0);
    assign ml_c   = mag(dl_c);
    assign mr_c   = mag(dr_c);
    assign peak_c = (ml_c > mr_c) ? ml_c : mr_c;

    assign pl_x   = CW'(pl_reg);
    assign thr_x  = CW'(thr_reg);
    assign diff_x = CW'(pl_x - thr_x);
    assign num_c  = DW'({diff_x, 24'd0});
    assign den_c  = DW'(prod[47:0]);

    always_comb begin
        mul_start = 1'b0;
        mul_a     = '0;
        mul_b     = '0;
        div_start = 1'b0;
        div_num   = '0;
        div_den   = '0;
        case (state_reg)
            S_PEAK: begin
                if (!(peak_c > pl_reg)) begin
                    mul_start = 1'b1;
                    mul_a     = MA'(W'(pl_reg - peak_c));
                    mul_b     = sskpl_pkg::MB'(rc_reg);
                end
            end
            S_THR: begin
                if (pl_x > thr_x) begin
                    mul_start = 1'b1;
                    mul_a     = MA'(kf_reg);
                    mul_b     = sskpl_pkg::MB'(thr_reg);
                    div_start = 1'b1;
                    div_num   = DW'(thr_reg);
                    div_den   = DW'(pl_reg);
                end
            end
            S_RATW: begin
                if (!mul_busy && !div_busy && den_c != '0 && num_c < den_c) begin
                    div_start = 1'b1;
                    div_num   = num_c;
                    div_den   = den_c;
                end
            end
            S_KNW: begin
                if (!div_busy) begin
                    mul_start = 1'b1;
                    mul_a     = MA'(ratio_reg);
                    mul_b     = sskpl_pkg::MB'(quo);
                end
            end
            S_SMS: begin
                mul_start = 1'b1;
                if (target_reg < gain_reg) begin
                    mul_a = MA'(25'(gain_reg - target_reg));
                    mul_b = sskpl_pkg::MB'(sskpl_pkg::ATTACK_Q24);
                end else begin
                    mul_a = MA'(25'(target_reg - gain_reg));
                    mul_b = sskpl_pkg::MB'(rc_reg);
                end
            end
            S_SCL: begin
                mul_start = 1'b1;
                mul_a     = MA'(mag(dl_reg));
                mul_b     = gain_reg;
            end
            S_LW: begin
                if (!mul_busy) begin
                    mul_start = 1'b1;
                    mul_a     = MA'(mag(dr_reg));
                    mul_b     = gain_reg;
                end
            end
            default: begin
            end
        endcase
    end

    sskpl_mul #(.MA(MA)) u_mul (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (mul_start),
        .a       (mul_a),
        .b       (mul_b),
        .busy    (mul_busy),
        .prod    (prod)
    );

    sskpl_div #(.DW(DW)) u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .num     (div_num),
        .den     (div_den),
        .busy    (div_busy),
        .quo     (quo)
    );

    // configuration
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            enable_reg <= 1'b1;
            thr_reg    <= sskpl_pkg::THRESHOLD_RST;
            rc_reg     <= sskpl_pkg::RELEASE_RST;
            kf_reg     <= sskpl_pkg::KNEE_RST;
            ceil_reg   <= sskpl_pkg::CEILING_RST;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                sskpl_pkg::REG_ENABLE:    enable_reg <= cfg_wdata[0];
                sskpl_pkg::REG_THRESHOLD: thr_reg    <= cfg_wdata[22:0];
                sskpl_pkg::REG_RELEASE:   rc_reg     <= cfg_wdata;
                sskpl_pkg::REG_KNEE:      kf_reg     <= cfg_wdata;
                sskpl_pkg::REG_CEILING:   ceil_reg   <= cfg_wdata[22:0];
                default: begin
                end
            endcase
        end
    end

    // control and limiter state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            m_valid_reg <= 1'b0;
            wp_reg      <= '0;
            fill_reg    <= '0;
            pl_reg      <= '0;
            gain_reg    <= sskpl_pkg::ONE_Q24;
        end else begin
            if (state_reg == S_OUT && (!m_valid_reg || m_ready)) begin
                m_valid_reg <= 1'b1;
            end else if (m_valid_reg && m_ready) begin
                m_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE: begin
                    if (s_fire) begin
                        state_reg <= enable_reg ? S_RD : S_OUT;
                    end
                end
                S_RD: begin
                    wp_reg    <= wp_next;
                    fill_reg  <= (fill_reg == FW'(RING_DEPTH)) ? fill_reg
                                                               : FW'(fill_reg + 1'b1);
                    state_reg <= S_PEAK;
                end
                S_PEAK: begin
                    if (peak_c > pl_reg) begin
                        pl_reg    <= peak_c;
                        state_reg <= S_THR;
                    end else begin
                        state_reg <= S_PKW;
                    end
                end
                S_PKW: begin
                    if (!mul_busy) begin
                        pl_reg    <= W'(pk_reg + prod[W+23:24]);
                        state_reg <= S_THR;
                    end
                end
                S_THR: begin
                    state_reg <= (pl_x > thr_x) ? S_RATW : S_SMS;
                end
                S_RATW: begin
                    if (!mul_busy && !div_busy) begin
                        state_reg <= (den_c != '0 && num_c < den_c) ? S_KNW : S_SMS;
                    end
                end
                S_KNW: begin
                    if (!div_busy) begin
                        state_reg <= S_BLW;
                    end
                end
                S_BLW: begin
                    if (!mul_busy) begin
                        state_reg <= S_SMS;
                    end
                end
                S_SMS: begin
                    state_reg <= S_SMW;
                end
                S_SMW: begin
                    if (!mul_busy) begin
                        gain_reg  <= down_reg ? 25'(target_reg + prod[48:24])
                                              : 25'(target_reg - prod[48:24]);
                        state_reg <= S_SCL;
                    end
                end
                S_SCL: begin
                    state_reg <= S_LW;
                end
                S_LW: begin
                    if (!mul_busy) begin
                        state_reg <= S_RW;
                    end
                end
                S_RW: begin
                    if (!mul_busy) begin
                        state_reg <= S_OUT;
                    end
                end
                S_OUT: begin
                    if (!m_valid_reg || m_ready) begin
                        state_reg <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
            // bypass mode holds write pointer, fill count, peak level and gain cleared
            if (!enable_reg) begin
                wp_reg   <= '0;
                fill_reg <= '0;
                pl_reg   <= '0;
                gain_reg <= sskpl_pkg::ONE_Q24;
            end
        end
    end

    // datapath registers
    always_ff @(posedge aclk) begin
        if (s_fire) begin
            in_l_reg  <= s_left_sample;
            in_r_reg  <= s_right_sample;
            in_be_reg <= s_block_end;
            lres_reg  <= s_left_sample;
            rres_reg  <= s_right_sample;
        end
        if (state_reg == S_RD) begin
            hit_reg <= (rd_addr == wp_reg);
            vld_reg <= (FW'(rd_addr) < fill_reg);
        end
        if (state_reg == S_PEAK) begin
            dl_reg <= dl_c;
            dr_reg <= dr_c;
            pk_reg <= peak_c;
        end
        if (state_reg == S_THR) begin
            target_reg <= sskpl_pkg::ONE_Q24;
        end
        if (state_reg == S_RATW && !mul_busy && !div_busy) begin
            ratio_reg  <= quo;
            target_reg <= 25'(quo);
        end
        if (state_reg == S_KNW && !div_busy) begin
            r_reg <= quo;
        end
        if (state_reg == S_BLW && !mul_busy) begin
            target_reg <= 25'(sskpl_pkg::ONE_Q24 - 25'(r_reg) + 25'(prod[47:24]));
        end
        if (state_reg == S_SMS) begin
            down_reg <= (target_reg < gain_reg);
        end
        if (state_reg == S_LW && !mul_busy) begin
            lres_reg <= clamp(dl_reg[W-1], prod, ceil_reg);
        end
        if (state_reg == S_RW && !mul_busy) begin
            rres_reg <= clamp(dr_reg[W-1], prod, ceil_reg);
        end
        if (state_reg == S_OUT && (!m_valid_reg || m_ready)) begin
            m_l_reg  <= lres_reg;
            m_r_reg  <= rres_reg;
            m_be_reg <= in_be_reg;
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_left_out      = m_l_reg;
    assign m_right_out     = m_r_reg;
    assign m_block_end_out = m_be_reg;
endmodule

@@ hw/rtl/sskpl_checker.sv @@
module sskpl_checker #(
    parameter int SAMPLE_BITS = 24
) (
    input logic                   aclk,
    input logic                   aresetn,
    input logic                   s_valid,
    input logic                   s_ready,
    input logic [SAMPLE_BITS-1:0] m_left_out,
    input logic [SAMPLE_BITS-1:0] m_right_out,
    input logic                   m_block_end_out,
    input logic                   m_valid,
    input logic                   m_ready
);
    // a stalled result holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_left_out) && $stable(m_right_out)
            && $stable(m_block_end_out))
        else $error("result changed while stalled");

    // one frame at a time
    a_busy_after_take: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("request taken while busy");

    a_reset_state: assert property (@(posedge aclk)
        !aresetn |=> !m_valid && s_ready)
        else $error("bad state after reset");
endmodule

bind stereo_soft_knee_peak_limiter_core sskpl_checker #(.SAMPLE_BITS(SAMPLE_BITS)) u_sskpl_chk (
    .aclk            (aclk),
    .aresetn         (aresetn),
    .s_valid         (s_valid),
    .s_ready         (s_ready),
    .m_left_out      (m_left_out),
    .m_right_out     (m_right_out),
    .m_block_end_out (m_block_end_out),
    .m_valid         (m_valid),
    .m_ready         (m_ready)
);

@@ test/tb_stereo_soft_knee_peak_limiter_core.sv @@
`timescale 1ns / 1ps

module tb_stereo_soft_knee_peak_limiter_core;

    localparam int DELAY  = 72;
    localparam int DEPTH  = 128;
    localparam int LIMIT  = 1500000;

    typedef struct {
        logic signed [23:0] left;
        logic signed [23:0] right;
        logic               blk;
    } frame_t;

    typedef struct {
        logic signed [23:0] left;
        logic signed [23:0] right;
        logic               blk;
        logic               known;
        logic signed [23:0] exp_l;
        logic signed [23:0] exp_r;
    } row_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_valid = 1'b0;
    logic s_ready;
    logic signed [23:0] s_left_sample = '0;
    logic signed [23:0] s_right_sample = '0;
    logic s_block_end = 1'b0;
    logic m_valid;
    logic m_ready = 1'b0;
    logic signed [23:0] m_left_out;
    logic signed [23:0] m_right_out;
    logic m_block_end_out;
    logic cfg_wr_en = 1'b0;
    logic [sskpl_pkg::CFG_IW-1:0] cfg_index = '0;
    logic [sskpl_pkg::CFG_DW-1:0] cfg_wdata = '0;

    always #5 aclk = ~aclk;

    stereo_soft_knee_peak_limiter_core u_top (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready),
        .s_left_sample(s_left_sample), .s_right_sample(s_right_sample),
        .s_block_end(s_block_end),
        .m_valid(m_valid), .m_ready(m_ready),
        .m_left_out(m_left_out), .m_right_out(m_right_out),
        .m_block_end_out(m_block_end_out),
        .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
    );

    // limiter model state and settings
    logic signed [23:0] dly_l [DEPTH];
    logic signed [23:0] dly_r [DEPTH];
    int unsigned  wr_pos;
    logic [63:0]  env_level;
    logic [63:0]  gain_q24;
    logic         lim_on;
    logic [63:0]  thr_lvl, rel_k, knee_k, ceil_lvl;

    frame_t expected_frames[$];
    int errors = 0;
    int n_out = 0;
    int n_sent = 0;
    int n_clamped = 0;
    int unsigned cyc = 0;
    bit rx_idle_en = 1'b1;
    int rx_hold = 0;

    function automatic logic [63:0] magnitude(logic signed [23:0] x);
        logic signed [63:0] w;
        w = x;
        return (w < 0) ? -w : w;
    endfunction

    function automatic logic [63:0] q24_quot(logic [63:0] num, logic [63:0] den);
        logic [63:0] rem, q;
        rem = num;
        q = 0;
        for (int i = 0; i < 24; i++) begin
            rem = rem << 1;
            q = q << 1;
            if (rem >= den) begin
                rem = rem - den;
                q[0] = 1'b1;
            end
        end
        return q;
    endfunction

    function automatic logic signed [23:0] gain_clamp(logic signed [23:0] x, logic [63:0] g);
        logic [63:0] m;
        m = (magnitude(x) * g) >> 24;
        if (m > ceil_lvl) m = ceil_lvl;
        return (x < 0) ? -m[23:0] : m[23:0];
    endfunction

    task automatic clear_limiter();
        for (int i = 0; i < DEPTH; i++) begin
            dly_l[i] = '0;
            dly_r[i] = '0;
        end
        wr_pos = 0;
        env_level = 0;
        gain_q24 = sskpl_pkg::ONE_Q24;
    endtask

    task automatic limit_frame(input frame_t fin, output frame_t fo);
        int unsigned rd;
        logic signed [23:0] dl, dr;
        logic [63:0] pk, tgt, ratio, num, den, r;
        fo.blk = fin.blk;
        if (!lim_on) begin
            clear_limiter();
            fo.left = fin.left;
            fo.right = fin.right;
            return;
        end
        dly_l[wr_pos] = fin.left;
        dly_r[wr_pos] = fin.right;
        rd = (wr_pos + DEPTH - (DELAY % DEPTH)) % DEPTH;
        dl = dly_l[rd];
        dr = dly_r[rd];
        pk = (magnitude(dl) > magnitude(dr)) ? magnitude(dl) : magnitude(dr);
        if (pk > env_level) env_level = pk;
        else env_level = pk + (((env_level - pk) * rel_k) >> 24);
        tgt = sskpl_pkg::ONE_Q24;
        if (env_level > thr_lvl) begin
            ratio = q24_quot(thr_lvl, env_level);
            num = (env_level - thr_lvl) << 24;
            den = knee_k * thr_lvl;
            if (den != 0 && num < den) begin
                r = q24_quot(num, den);
                tgt = (sskpl_pkg::ONE_Q24 - r) + ((ratio * r) >> 24);
            end else begin
                tgt = ratio;
            end
        end
        if (tgt < gain_q24)
            gain_q24 = tgt + (((gain_q24 - tgt) * sskpl_pkg::ATTACK_Q24) >> 24);
        else gain_q24 = tgt - (((tgt - gain_q24) * rel_k) >> 24);
        fo.left = gain_clamp(dl, gain_q24);
        fo.right = gain_clamp(dr, gain_q24);
        if (magnitude(dl) * gain_q24 >> 24 > ceil_lvl) n_clamped++;
        wr_pos = (wr_pos + 1) % DEPTH;
    endtask

    task automatic write_reg(input logic [sskpl_pkg::CFG_IW-1:0] idx, input logic [63:0] val);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val[sskpl_pkg::CFG_DW-1:0];
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        case (idx)
            sskpl_pkg::REG_ENABLE: begin
                lim_on = val[0];
                if (!lim_on) clear_limiter();
            end
            sskpl_pkg::REG_THRESHOLD: thr_lvl = val & 64'h7FFFFF;
            sskpl_pkg::REG_RELEASE:   rel_k = val & 64'hFFFFFF;
            sskpl_pkg::REG_KNEE:      knee_k = val & 64'hFFFFFF;
            sskpl_pkg::REG_CEILING:   ceil_lvl = val & 64'h7FFFFF;
            default: ;
        endcase
        @(posedge aclk);
    endtask

    // send one request; idles beforehand at random when allowed
    task automatic send_frame(input frame_t f, input bit may_idle);
        frame_t fo;
        if (may_idle) begin
            while ($urandom_range(99) < 30) begin
                s_valid <= 1'b0;
                @(posedge aclk);
            end
        end
        s_valid <= 1'b1;
        s_left_sample <= f.left;
        s_right_sample <= f.right;
        s_block_end <= f.blk;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        limit_frame(f, fo);
        expected_frames.push_back(fo);
        n_sent++;
    endtask

    task automatic drain();
        s_valid <= 1'b0;
        while (expected_frames.size() != 0) @(posedge aclk);
        // a frame still in flight could follow; let the block settle
        repeat (400) @(posedge aclk);
    endtask

    function automatic logic signed [23:0] rnd_sample();
        case ($urandom_range(5))
            0: return 24'sh7FFFFF;
            1: return 24'sh800000;
            2: return 24'($urandom_range(8388607, 7000000));
            3: return -$signed({1'b0, 23'($urandom_range(8388607, 7000000))});
            4: return 24'($urandom_range(4000));
            default: return 24'($urandom);
        endcase
    endfunction

    task automatic random_frames(input int n, input bit may_idle);
        frame_t f;
        for (int i = 0; i < n; i++) begin
            f.left = rnd_sample();
            f.right = ($urandom_range(3) == 0) ? f.left : rnd_sample();
            f.blk = 1'($urandom_range(1));
            send_frame(f, may_idle);
        end
    endtask

    // result checking
    always @(posedge aclk) begin
        frame_t e;
        if (aresetn && m_valid && m_ready) begin
            if (expected_frames.size() == 0) begin
                $display("%0t: unexpected result L=%0d R=%0d", $time, m_left_out, m_right_out);
                errors++;
            end else begin
                e = expected_frames.pop_front();
                n_out++;
                if (m_left_out !== e.left) begin
                    $display("%0t: left_out expected %0d actual %0d", $time, e.left, m_left_out);
                    errors++;
                end
                if (m_right_out !== e.right) begin
                    $display("%0t: right_out expected %0d actual %0d",
                             $time, e.right, m_right_out);
                    errors++;
                end
                if (m_block_end_out !== e.blk) begin
                    $display("%0t: block_end_out expected %0b actual %0b",
                             $time, e.blk, m_block_end_out);
                    errors++;
                end
            end
        end
    end

    // receiver: random stalls, or a long hold-off when requested
    always @(posedge aclk) begin
        if (rx_hold > 0) begin
            rx_hold <= rx_hold - 1;
            m_ready <= 1'b0;
        end else begin
            m_ready <= rx_idle_en ? ($urandom_range(99) >= 30) : 1'b1;
        end
    end

    always @(posedge aclk) begin
        cyc <= cyc + 1;
        if (cyc > LIMIT) begin
            $display("%0t: timeout", $time);
            $display("Verification failed");
            $finish;
        end
    end

    initial begin
        row_t rows[$];
        row_t rw;
        frame_t f, fo;
        lim_on = 1'b1;
        thr_lvl = sskpl_pkg::THRESHOLD_RST;
        rel_k = sskpl_pkg::RELEASE_RST;
        knee_k = sskpl_pkg::KNEE_RST;
        ceil_lvl = sskpl_pkg::CEILING_RST;
        clear_limiter();
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // first DELAY frames after reset read empty ring slots: zero out
        rows.push_back('{24'sh7FFFFF, 24'sh800000, 1'b1, 1'b1, 24'sd0, 24'sd0});
        rows.push_back('{24'sh800000, 24'sh7FFFFF, 1'b0, 1'b1, 24'sd0, 24'sd0});
        rows.push_back('{24'sd0, 24'sd0, 1'b1, 1'b1, 24'sd0, 24'sd0});
        rows.push_back('{24'sd1, -24'sd1, 1'b0, 1'b1, 24'sd0, 24'sd0});
        foreach (rows[i]) begin
            rw = rows[i];
            f = '{rw.left, rw.right, rw.blk};
            send_frame(f, 1'b0);
            if (rw.known) begin
                fo = expected_frames[$];
                if (fo.left !== rw.exp_l || fo.right !== rw.exp_r) begin
                    $display("%0t: table row %0d expected %0d/%0d model %0d/%0d",
                             $time, i, rw.exp_l, rw.exp_r, fo.left, fo.right);
                    errors++;
                end
            end
        end
        // loud burst long enough to reach the output through the delay
        for (int i = 0; i < 90; i++) begin
            f.left = (i % 2) ? 24'sh7FFFFF : 24'sh800000;
            f.right = 24'sh400000;
            f.blk = (i % 16 == 15);
            send_frame(f, 1'b0);
        end
        drain();

        // bypass: outputs equal inputs, read straight off
        write_reg(sskpl_pkg::REG_ENABLE, 0);
        rows.delete();
        rows.push_back('{24'sh7FFFFF, 24'sh800000, 1'b1, 1'b1, 24'sh7FFFFF, 24'sh800000});
        rows.push_back('{-24'sd5, 24'sd9, 1'b0, 1'b1, -24'sd5, 24'sd9});
        foreach (rows[i]) begin
            rw = rows[i];
            send_frame('{rw.left, rw.right, rw.blk}, 1'b0);
            fo = expected_frames[$];
            if (fo.left !== rw.exp_l || fo.right !== rw.exp_r) begin
                $display("%0t: bypass row %0d mismatch in table", $time, i);
                errors++;
            end
        end
        random_frames(40, 1'b1);
        drain();

        // setting sweep, extremes included
        for (int ph = 0; ph < 8; ph++) begin
            write_reg(sskpl_pkg::REG_ENABLE, 1);
            case (ph)
                0: begin
                    write_reg(sskpl_pkg::REG_THRESHOLD, 2107102);
                    write_reg(sskpl_pkg::REG_RELEASE, 0);
                    write_reg(sskpl_pkg::REG_KNEE, 1);
                    write_reg(sskpl_pkg::REG_CEILING, 0);
                end
                1: begin
                    write_reg(sskpl_pkg::REG_THRESHOLD, 8103826);
                    write_reg(sskpl_pkg::REG_RELEASE, 16777215);
                    write_reg(sskpl_pkg::REG_KNEE, 16777215);
                    write_reg(sskpl_pkg::REG_CEILING, 8388607);
                end
                2: begin
                    // zero threshold: hard region, zero gain
                    write_reg(sskpl_pkg::REG_THRESHOLD, 0);
                    write_reg(sskpl_pkg::REG_KNEE, 0);
                    write_reg(sskpl_pkg::REG_CEILING, 4000000);
                end
                3: write_reg(sskpl_pkg::REG_THRESHOLD, 8388607);
                default: begin
                    write_reg(sskpl_pkg::REG_THRESHOLD, $urandom_range(8103826, 2107102));
                    write_reg(sskpl_pkg::REG_RELEASE, $urandom_range(16777215));
                    write_reg(sskpl_pkg::REG_KNEE, $urandom_range(16777215, 1));
                    write_reg(sskpl_pkg::REG_CEILING, $urandom_range(8388607));
                end
            endcase
            if (ph == 4) begin
                // long receiver hold-off while requests keep coming
                rx_hold = 600;
                random_frames(40, 1'b0);
            end
            if (ph == 5) begin
                rx_idle_en = 1'b0;
                random_frames(120, 1'b0);
                rx_idle_en = 1'b1;
            end
            random_frames(130, 1'b1);
            drain();
        end

        $display("Sent %0d frames, checked %0d results (%0d clamped) over 8 settings",
                 n_sent, n_out, n_clamped);
        $display("plus bypass, reset-state and full-scale burst phases");
        if (errors == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
